// ----- src/cslf_pkg.sv -----
// ----------------------------------------------------------------------------
// cslf_pkg
// Shared types and codes of the conditional section line filter.
// ----------------------------------------------------------------------------
package cslf_pkg;

	localparam int KIND_W   = 4;
	localparam int ACTION_W = 2;
	localparam int REWR_W   = 2;
	localparam int ERR_W    = 3;
	localparam int NEST_W   = 7;
	localparam int REJ_W    = 2;
	localparam int FLAG_W   = 4;
	localparam int CFG_IDX_W = 2;

	// line kinds
	localparam logic [KIND_W-1:0] KIND_PLAIN      = 4'd0;
	localparam logic [KIND_W-1:0] KIND_IF_UNK     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_IF_TRUE    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_IF_FALSE   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_ELIF_UNK   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_ELIF_TRUE  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_ELIF_FALSE = 4'd6;
	localparam logic [KIND_W-1:0] KIND_ELSE       = 4'd7;
	localparam logic [KIND_W-1:0] KIND_ENDIF      = 4'd8;
	localparam logic [KIND_W-1:0] KIND_EOF        = 4'd9;

	// line actions
	localparam logic [ACTION_W-1:0] ACT_EMIT  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BLANK = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DROP  = 2'd2;

	// rewrites
	localparam logic [REWR_W-1:0] RW_NONE     = 2'd0;
	localparam logic [REWR_W-1:0] RW_TO_IF    = 2'd1;
	localparam logic [REWR_W-1:0] RW_TO_ENDIF = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [ERR_W-1:0] ERR_ELIF     = 3'd1;
	localparam logic [ERR_W-1:0] ERR_ELSE     = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ENDIF    = 3'd3;
	localparam logic [ERR_W-1:0] ERR_EOF_IN   = 3'd4;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd5;

	// reject levels
	localparam logic [REJ_W-1:0] REJ_PASS   = 2'd0;
	localparam logic [REJ_W-1:0] REJ_SKIP   = 2'd1;
	localparam logic [REJ_W-1:0] REJ_REJECT = 2'd2;

	// level flag bits
	localparam int FL_ACTIVE = 0;
	localparam int FL_DONE   = 1;
	localparam int FL_IGN    = 2;
	localparam int FL_ELSE   = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COMPLEMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS   = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] line_kind;
		logic              sym_ignored;
		logic              in_comment;
	} item_t;

	typedef struct packed {
		logic [ACTION_W-1:0] line_action;
		logic [REWR_W-1:0]   rewrite;
		logic [ERR_W-1:0]    error_code;
		logic [NEST_W-1:0]   nest_level;
		logic                finished;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic                 value;
	} cfg_t;

	typedef struct packed {
		logic [REJ_W-1:0]  saved;
		logic [FLAG_W-1:0] flags;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/cslf_stream_if.sv -----
// ----------------------------------------------------------------------------
// cslf_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface cslf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/cslf_ram.sv -----
// ----------------------------------------------------------------------------
// cslf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cslf_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/conditional_section_line_filter_top.sv -----
// ----------------------------------------------------------------------------
// conditional_section_line_filter_top
// Line filter for conditional sections: one classified line in, one verdict out.
//
// item carries one classified line per word; result returns one word per item
// with the line action, elif rewrite, latched error, depth and end-of-file mark.
// cfg writes the three mode registers (index 0 complement, 1 blank, 2 suppress);
// it is always ready and should only be written while the filter is idle.
// An accepted item sits in the input register and its result is loaded into
// the output register when the output register is free or being taken.
// One item is taken every cycle unless result stalls; the nesting stack
// keeps its top entry in flops and the entries below in a RAM read ahead,
// so a push, pop or top update finishes in the cycle of the item.
// A stalled result holds the output register; the input register then fills
// and item.ready drops until result is taken.
// Reset clears the modes, reject level, depth, error latch and both valid
// stages; stack entries are only read after being pushed and are not cleared.
// ----------------------------------------------------------------------------
module conditional_section_line_filter_top #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	cslf_stream_if.sink             item,
	cslf_stream_if.source           result,
	cslf_stream_if.sink             cfg
);
	import cslf_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	// configuration
	logic complement_q, blank_q, suppress_q;
	cfg_t cfg_word;

	// input stage
	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	// state
	logic [REJ_W-1:0] rej_q, rej_n;
	logic [DW-1:0]    depth_q, depth_n;
	logic [ERR_W-1:0] err_q, err_n;
	entry_t           top_q, top_n;
	entry_t           below;
	logic             push;

	// stack ram side
	logic             byp_valid_q;
	entry_t           byp_q;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [DW-1:0]    depth_d;
	logic [DW-1:0]    depth_m1, depth_d_m2;
	logic             ram_we;

	// output stage
	logic    res_valid_q;
	result_t res_q;
	result_t res_n;

	function automatic logic [ACTION_W-1:0] decide(
		input logic             keep,
		input logic [REJ_W-1:0] rej,
		input logic             comp,
		input logic             blank,
		input logic             supp
	);
		logic [ACTION_W-1:0] a;
		if (supp) begin
			a = ACT_DROP;
		end else if ((keep && (rej != REJ_REJECT)) != comp) begin
			a = ACT_EMIT;
		end else begin
			a = blank ? ACT_BLANK : ACT_DROP;
		end
		return a;
	endfunction

	assign cfg_word = cfg.data;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complement_q <= 1'b0;
			blank_q      <= 1'b0;
			suppress_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_word.index)
				CFG_COMPLEMENT: complement_q <= cfg_word.value;
				CFG_BLANK:      blank_q      <= cfg_word.value;
				CFG_SUPPRESS:   suppress_q   <= cfg_word.value;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	// entry below the top: ram read issued ahead from the next depth, bypass after a push
	assign below = byp_valid_q ? byp_q : entry_t'(ram_rdata);

	// line decision
	always_comb begin
		logic [KIND_W-1:0] kind;
		logic [FLAG_W-1:0] fl;
		logic [REJ_W-1:0]  saved;
		logic [ERR_W-1:0]  err;
		logic [ACTION_W-1:0] act;
		logic [REWR_W-1:0] rw;

		kind  = (item_s1.line_kind > KIND_EOF) ? KIND_PLAIN : item_s1.line_kind;
		fl    = top_q.flags;
		saved = top_q.saved;
		err   = ERR_NONE;
		act   = ACT_DROP;
		rw    = RW_NONE;
		rej_n   = rej_q;
		depth_n = depth_q;
		top_n   = top_q;
		push    = 1'b0;

		if (err_q != ERR_NONE) begin
			// frozen after the first error
		end else begin
			unique case (kind)
				KIND_IF_UNK, KIND_IF_TRUE, KIND_IF_FALSE: begin
					if (depth_q >= DW'(MAX_DEPTH)) begin
						err = ERR_OVERFLOW;
					end else begin
						fl = '0;
						if (kind == KIND_IF_UNK || rej_q != REJ_PASS) begin
							act = decide(1'b1, rej_q, complement_q, blank_q, suppress_q);
						end else if (item_s1.sym_ignored) begin
							fl[FL_IGN] = 1'b1;
							act = decide(1'b1, rej_q, complement_q, blank_q, suppress_q);
							if (kind == KIND_IF_FALSE) begin
								rej_n = REJ_SKIP;
							end else begin
								fl[FL_DONE] = 1'b1;
							end
						end else begin
							fl[FL_ACTIVE] = 1'b1;
							act = decide(1'b0, rej_q, complement_q, blank_q, suppress_q);
							if (kind == KIND_IF_FALSE) begin
								rej_n = REJ_REJECT;
							end else begin
								fl[FL_DONE] = 1'b1;
							end
						end
						top_n.saved = rej_q;
						top_n.flags = fl;
						depth_n = depth_q + 1'b1;
						push = 1'b1;
					end
				end
				KIND_EOF: begin
					if (item_s1.in_comment) begin
						err = ERR_OVERFLOW;
					end else if (depth_q != '0) begin
						err = ERR_EOF_IN;
					end
				end
				KIND_ELIF_UNK, KIND_ELIF_TRUE, KIND_ELIF_FALSE, KIND_ELSE,
				KIND_ENDIF: begin
					if (depth_q == '0) begin
						if (kind == KIND_ENDIF) begin
							err = ERR_ENDIF;
						end else if (kind == KIND_ELSE) begin
							err = ERR_ELSE;
						end else begin
							err = ERR_ELIF;
						end
					end else if (kind == KIND_ELIF_UNK) begin
						if (fl[FL_ELSE]) begin
							err = ERR_ELIF;
						end else begin
							fl[FL_DONE] = 1'b0;
							rej_n = saved;
							if (fl[FL_ACTIVE]) begin
								fl[FL_ACTIVE] = 1'b0;
								rw = RW_TO_IF;
							end else begin
								fl[FL_IGN] = 1'b0;
							end
							act = decide(1'b1, saved, complement_q, blank_q, suppress_q);
							top_n.flags = fl;
						end
					end else if (kind == KIND_ELIF_TRUE || kind == KIND_ELIF_FALSE) begin
						if (fl[FL_ELSE]) begin
							err = ERR_ELIF;
						end else begin
							if (fl[FL_ACTIVE]) begin
								act = decide(1'b0, rej_q, complement_q, blank_q, suppress_q);
							end else begin
								fl[FL_IGN]    = 1'b0;
								fl[FL_ACTIVE] = 1'b1;
								rw = RW_TO_ENDIF;
								act = decide(1'b1, rej_q, complement_q, blank_q, suppress_q);
							end
							if (kind == KIND_ELIF_FALSE) begin
								rej_n = REJ_REJECT;
							end else begin
								rej_n = REJ_PASS;
								fl[FL_DONE] = 1'b1;
							end
							top_n.flags = fl;
						end
					end else if (kind == KIND_ELSE) begin
						if (fl[FL_ELSE]) begin
							err = ERR_ELSE;
						end else begin
							if (fl[FL_ACTIVE]) begin
								act = decide(1'b0, rej_q, complement_q, blank_q, suppress_q);
								if (rej_q == REJ_REJECT && !fl[FL_DONE]) begin
									rej_n = REJ_PASS;
								end else begin
									rej_n = REJ_REJECT;
								end
							end else begin
								act = decide(1'b1, rej_q, complement_q, blank_q, suppress_q);
								if (fl[FL_IGN]) begin
									rej_n = (rej_q == REJ_SKIP) ? REJ_PASS : REJ_SKIP;
								end
							end
							fl[FL_ELSE] = 1'b1;
							top_n.flags = fl;
						end
					end else begin
						act = decide(!fl[FL_ACTIVE], rej_q, complement_q, blank_q, suppress_q);
						rej_n = saved;
						depth_n = depth_q - 1'b1;
						top_n = below;
					end
				end
				default: begin
					act = decide(1'b1, rej_q, complement_q, blank_q, suppress_q);
				end
			endcase
		end

		err_n = err_q;
		if (err != ERR_NONE) begin
			err_n = err;
			act   = ACT_DROP;
			rw    = RW_NONE;
		end

		res_n.line_action = act;
		res_n.rewrite     = rw;
		res_n.error_code  = err_n;
		res_n.nest_level  = NEST_W'(depth_n);
		res_n.finished    = (kind == KIND_EOF);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q   <= REJ_PASS;
			depth_q <= '0;
			err_q   <= ERR_NONE;
		end else if (advance) begin
			rej_q   <= rej_n;
			depth_q <= depth_n;
			err_q   <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			top_q <= top_n;
		end
	end

	// stack below the top
	assign depth_d    = advance ? depth_n : depth_q;
	assign depth_m1   = depth_q - 1'b1;
	assign depth_d_m2 = depth_d - DW'(2);
	assign ram_we     = advance && push && (depth_q != '0);

	cslf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(depth_m1[AW-1:0]),
		.wdata(top_q),
		.raddr(depth_d_m2[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else begin
			byp_valid_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			byp_q <= top_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;
endmodule
